// ===== rtl/core/icmprw_pkg.sv =====
// Shared types and constants for the ICMP redirect header rewriter.
`timescale 1ns / 1ps
package icmprw_pkg;

  localparam int unsigned HDR_LEN = 34;
  localparam int unsigned ETH_LEN = 14;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned CFG_IW  = 2;
  localparam int unsigned CFG_DW  = 48;

  localparam logic [7:0] ETHTYPE_HI = 8'h08;
  localparam logic [7:0] ETHTYPE_LO = 8'h00;
  localparam logic [7:0] PROTO_ICMP = 8'h01;

  localparam logic [CFG_IW-1:0] REG_SERVER_IP    = 2'd0;
  localparam logic [CFG_IW-1:0] REG_SERVER_MAC   = 2'd1;
  localparam logic [CFG_IW-1:0] REG_SERVER_VALID = 2'd2;

  typedef enum logic [1:0] {
    V_TX    = 2'd0,
    V_PASS  = 2'd1,
    V_DROP  = 2'd2,
    V_ABORT = 2'd3
  } verdict_t;

  typedef enum logic [2:0] {
    S_CAP  = 3'b001,
    S_EMIT = 3'b010,
    S_PASS = 3'b100
  } state_t;

endpackage

// ===== rtl/core/icmp_redirect_header_rewriter.sv =====
// Top level: Ethernet/IPv4 header capture, ICMP redirect rewrite and checksum update.
// Capture: the first 34 bytes (or the whole frame, if shorter) are held, then sent as a
// burst via the registered read of the single-read-port header RAM.
// Throughput: 1 byte per cycle while capturing, and while passing through or bursting
// unless the output stalls; input stalls during the burst. Reset: synchronous, clears
// control and config state; payload registers and header RAM are not cleared.
`timescale 1ns / 1ps
module icmp_redirect_header_rewriter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [icmprw_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [icmprw_pkg::CFG_DW-1:0]  cfg_data,
  input  logic                           frame_valid,
  output logic                           frame_stall,
  input  logic [7:0]                     frame_byte,
  input  logic                           frame_last,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_byte,
  output logic                           out_last,
  output logic [1:0]                     verdict
);

  import icmprw_pkg::*;

  localparam logic [POS_W-1:0] HDR_N = POS_W'(HDR_LEN);
  localparam logic [POS_W-1:0] ETH_N = POS_W'(ETH_LEN);

  // configuration
  logic [31:0] server_ip;
  logic [47:0] server_mac;
  logic        server_valid;

  // control
  state_t           state;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] count;
  logic             frame_end;
  verdict_t         fv;
  logic [7:0]       eth_hi;
  logic [7:0]       eth_lo;
  logic [7:0]       proto;
  logic [19:0]      sum;
  logic [15:0]      csum;

  // emit side
  logic [POS_W-1:0] rd_addr;
  logic [POS_W-1:0] data_idx;
  logic             data_valid;
  logic [7:0]       ram_rdata;

  logic             in_acc;
  logic             out_free;
  logic             load_emit;
  logic             load_pass;
  logic             issue;
  logic             emit_end;
  logic [POS_W-1:0] pos_next;
  logic             decide_now;
  logic [7:0]       eth_hi_next;
  logic [7:0]       eth_lo_next;
  logic [7:0]       proto_next;
  logic [19:0]      sum_base;
  logic [19:0]      sum_next;
  verdict_t         fv_next;
  logic [19:0]      tot;
  logic [16:0]      fold1;
  logic [16:0]      fold2;
  logic [7:0]       emit_byte;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      server_ip    <= '0;
      server_mac   <= '0;
      server_valid <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SERVER_IP:    server_ip    <= cfg_data[31:0];
        REG_SERVER_MAC:   server_mac   <= cfg_data[47:0];
        REG_SERVER_VALID: server_valid <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign out_free    = !out_valid || !out_stall;
  assign frame_stall = (state == S_EMIT) || ((state == S_PASS) && !out_free);
  assign in_acc      = frame_valid && !frame_stall;
  assign load_pass   = in_acc && (state == S_PASS);
  assign load_emit   = (state == S_EMIT) && data_valid && out_free;
  assign issue       = (state == S_EMIT) && (rd_addr < count) && (!data_valid || load_emit);
  assign emit_end    = (POS_W'(data_idx + 1'b1) == count);

  // capture-side field tracking
  assign pos_next    = POS_W'(pos + 1'b1);
  assign decide_now  = in_acc && (state == S_CAP) && (frame_last || pos_next == HDR_N);
  assign eth_hi_next = (pos == POS_W'(12)) ? frame_byte : eth_hi;
  assign eth_lo_next = (pos == POS_W'(13)) ? frame_byte : eth_lo;
  assign proto_next  = (pos == POS_W'(23)) ? frame_byte : proto;
  assign sum_base    = (pos == '0) ? 20'd0 : sum;

  // sum the header words except the checksum and destination IP, which are replaced
  always_comb begin
    sum_next = sum_base;
    if (pos >= ETH_N && pos < POS_W'(30) && pos != POS_W'(24) && pos != POS_W'(25)) begin
      if (pos[0]) begin
        sum_next = sum_base + {12'd0, frame_byte};
      end else begin
        sum_next = sum_base + {4'd0, frame_byte, 8'd0};
      end
    end
  end

  always_comb begin
    priority if (pos_next < ETH_N) begin
      fv_next = V_DROP;
    end else if (eth_hi_next != ETHTYPE_HI || eth_lo_next != ETHTYPE_LO) begin
      fv_next = V_PASS;
    end else if (pos_next < HDR_N) begin
      fv_next = V_DROP;
    end else if (proto_next != PROTO_ICMP) begin
      fv_next = V_PASS;
    end else if (!server_valid) begin
      fv_next = V_ABORT;
    end else begin
      fv_next = V_TX;
    end
  end

  // fold with the new destination IP, then ones-complement
  assign tot   = sum + {4'd0, server_ip[31:16]} + {4'd0, server_ip[15:0]};
  assign fold1 = {1'b0, tot[15:0]} + {13'd0, tot[19:16]};
  assign fold2 = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};

  icmprw_ram #(
    .WIDTH (8),
    .DEPTH (HDR_LEN)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (in_acc && (state == S_CAP)),
    .waddr (pos),
    .wdata (frame_byte),
    .re    (issue),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // header substitution for a rewritten frame
  always_comb begin
    emit_byte = ram_rdata;
    if (fv == V_TX) begin
      unique case (data_idx)
        POS_W'(0):  emit_byte = server_mac[47:40];
        POS_W'(1):  emit_byte = server_mac[39:32];
        POS_W'(2):  emit_byte = server_mac[31:24];
        POS_W'(3):  emit_byte = server_mac[23:16];
        POS_W'(4):  emit_byte = server_mac[15:8];
        POS_W'(5):  emit_byte = server_mac[7:0];
        POS_W'(24): emit_byte = csum[15:8];
        POS_W'(25): emit_byte = csum[7:0];
        POS_W'(30): emit_byte = server_ip[31:24];
        POS_W'(31): emit_byte = server_ip[23:16];
        POS_W'(32): emit_byte = server_ip[15:8];
        POS_W'(33): emit_byte = server_ip[7:0];
        default:    emit_byte = ram_rdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CAP;
      pos        <= '0;
      count      <= '0;
      frame_end  <= 1'b0;
      fv         <= V_PASS;
      sum        <= '0;
      rd_addr    <= '0;
      data_idx   <= '0;
      data_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (load_emit || load_pass) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CAP: begin
          if (in_acc) begin
            pos <= pos_next;
            sum <= sum_next;
            if (decide_now) begin
              state      <= S_EMIT;
              count      <= pos_next;
              frame_end  <= frame_last;
              fv         <= fv_next;
              rd_addr    <= '0;
              data_valid <= 1'b0;
            end
          end
        end
        S_EMIT: begin
          if (issue) begin
            rd_addr  <= POS_W'(rd_addr + 1'b1);
            data_idx <= rd_addr;
          end
          if (issue) begin
            data_valid <= 1'b1;
          end else if (load_emit) begin
            data_valid <= 1'b0;
          end
          if (load_emit && emit_end) begin
            if (frame_end) begin
              state <= S_CAP;
              pos   <= '0;
            end else begin
              state <= S_PASS;
            end
          end
        end
        S_PASS: begin
          if (load_pass && frame_last) begin
            state <= S_CAP;
            pos   <= '0;
          end
        end
        default: state <= S_CAP;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_EMIT) begin
      csum <= ~fold2[15:0] & 16'hffff;
    end
    if (in_acc && (state == S_CAP)) begin
      eth_hi <= eth_hi_next;
      eth_lo <= eth_lo_next;
      proto  <= proto_next;
    end
    if (load_emit) begin
      out_byte <= emit_byte;
      out_last <= frame_end && emit_end;
      verdict  <= (frame_end && emit_end) ? fv : V_TX;
    end else if (load_pass) begin
      out_byte <= frame_byte;
      out_last <= frame_last;
      verdict  <= frame_last ? fv : V_TX;
    end
  end

  a_verdict_only_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> verdict == V_TX)
    else $error("verdict set on an item that is not last");

  a_pos_bounded: assert property (@(posedge clk) disable iff (rst)
    pos <= HDR_N)
    else $error("byte position beyond header length");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    data_valid |-> data_idx < count)
    else $error("header read beyond held bytes");

  a_burst_after_header: assert property (@(posedge clk) disable iff (rst)
    decide_now |=> state == S_EMIT && !data_valid)
    else $error("header burst did not start after capture");

endmodule

// ===== rtl/core/icmprw_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module icmprw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 34
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
